>>> rtl/itdc_pkg.sv
// Shared constants for the integer-to-decimal-with-commas unit.
package itdc_pkg;

	localparam int ITDC_VALUE_BITS = 64;
	localparam int BCD_W           = 4;
	localparam int GROUP_SIZE      = 3;

	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_COMMA = 7'h2c;
	localparam logic [6:0] CHAR_MINUS = 7'h2d;

endpackage

>>> rtl/int_to_decimal_with_commas_unit.sv
// Top level: signed integer to ASCII decimal text with thousands separators.
//
//  channel   signals                 direction  notes
//  -------   ---------------------   ---------  ------------------------------------
//  command   start, value[63:0]      in         taken when start & !busy
//  status    busy                    out        high from accept to last char queued
//  result    strobe, char_code, last out        one char per strobe, no back-pressure
//
// Sequence: one shift-add-3 conversion step per input bit, then a minus sign
// for a negative value, then one slot per digit position (leading zeros are
// skipped one per cycle) with commas between groups of three. Busy drops
// while the last char is shown, so the next transaction can be taken then.
// Reset clears the sequencer and the result strobe; data registers are not reset.
// The receiver cannot stall: each character is shown for exactly one cycle.
module int_to_decimal_with_commas_unit import itdc_pkg::*; #(
	parameter int VALUE_BITS = ITDC_VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] value,
	output logic        strobe,
	output logic [6:0]  char_code,
	output logic        last
);

	// enough digits for 2^(VALUE_BITS-1): log10(2) < 0.31
	localparam int NDIG     = (VALUE_BITS * 31) / 100 + 1;
	localparam int BCD_BITS = NDIG * BCD_W;
	localparam int IDX_W    = $clog2(NDIG);
	localparam int CNT_W    = $clog2(VALUE_BITS);
	localparam logic [1:0] GRP_INIT = 2'((NDIG - 1) % GROUP_SIZE);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CONV  = 5'b00010,
		ST_SIGN  = 5'b00100,
		ST_DIGIT = 5'b01000,
		ST_COMMA = 5'b10000
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  neg_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic [CNT_W-1:0]      bit_cnt_q;
	logic [IDX_W-1:0]      idx_q;     // decimal position of the digit at the top
	logic [1:0]            grp_q;     // idx_q mod 3
	logic                  lead_q;    // still in leading zeros
	logic                  strobe_q;
	logic [6:0]            char_q;
	logic                  last_q;

	logic [VALUE_BITS-1:0] in_v;
	logic [BCD_BITS-1:0]   bcd_next;
	logic [BCD_W-1:0]      top_dig;
	logic                  idx_zero;
	logic                  skip;

	assign in_v     = value[VALUE_BITS-1:0];
	assign top_dig  = bcd_q[BCD_BITS-1 -: BCD_W];
	assign idx_zero = (idx_q == '0);
	assign skip     = lead_q && (top_dig == '0) && !idx_zero;

	// shared conversion step, used once per magnitude bit
	itdc_dabble #(.NDIG(NDIG)) u_dabble (
		.bcd_in  (bcd_q),
		.bit_in  (mag_q[VALUE_BITS-1]),
		.bcd_out (bcd_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (bit_cnt_q == CNT_W'(VALUE_BITS - 1)) begin
						state_q <= neg_q ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= ST_DIGIT;
				end
				ST_DIGIT: begin
					if (!skip) begin
						strobe_q <= 1'b1;
						if (idx_zero) begin
							state_q <= ST_IDLE;
						end else if (grp_q == 2'd0) begin
							state_q <= ST_COMMA;
						end
					end
				end
				ST_COMMA: begin
					strobe_q <= 1'b1;
					state_q  <= ST_DIGIT;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: magnitude, BCD shifter, position counters, result regs
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				neg_q     <= in_v[VALUE_BITS-1];
				// most negative value wraps to its own unsigned magnitude
				mag_q     <= in_v[VALUE_BITS-1] ? (~in_v + 1'b1) : in_v;
				bcd_q     <= '0;
				bit_cnt_q <= '0;
			end
			ST_CONV: begin
				bcd_q     <= bcd_next;
				mag_q     <= {mag_q[VALUE_BITS-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q + 1'b1;
				idx_q     <= IDX_W'(NDIG - 1);
				grp_q     <= GRP_INIT;
				lead_q    <= 1'b1;
			end
			ST_SIGN: begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
			end
			ST_DIGIT: begin
				if (!skip) begin
					char_q <= CHAR_ZERO + {3'b000, top_dig};
					last_q <= idx_zero;
					lead_q <= 1'b0;
				end
				if (!idx_zero) begin
					bcd_q <= {bcd_q[BCD_BITS-BCD_W-1:0], {BCD_W{1'b0}}};
					idx_q <= idx_q - 1'b1;
					grp_q <= (grp_q == 2'd0) ? 2'(GROUP_SIZE - 1) : grp_q - 1'b1;
				end
			end
			ST_COMMA: begin
				char_q <= CHAR_COMMA;
				last_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;

endmodule

>>> rtl/itdc_dabble.sv
// One shift-add-3 step of the binary-to-BCD converter.
module itdc_dabble import itdc_pkg::*; #(
	parameter int NDIG = 20
) (
	input  logic [NDIG*BCD_W-1:0] bcd_in,
	input  logic                  bit_in,
	output logic [NDIG*BCD_W-1:0] bcd_out
);

	logic [NDIG*BCD_W-1:0] adj;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_in[i*BCD_W +: BCD_W] >= BCD_W'(5)) begin
				adj[i*BCD_W +: BCD_W] = bcd_in[i*BCD_W +: BCD_W] + BCD_W'(3);
			end else begin
				adj[i*BCD_W +: BCD_W] = bcd_in[i*BCD_W +: BCD_W];
			end
		end
	end

	// top bit falls off: digit count is sized so it is always zero
	assign bcd_out = {adj[NDIG*BCD_W-2:0], bit_in};

endmodule

>>> test/int_to_decimal_with_commas_unit_tb.sv
// Self-checking testbench for the integer-to-decimal-with-commas unit.
`timescale 1ns / 100ps

module int_to_decimal_with_commas_unit_tb;
	import itdc_pkg::*;

	localparam int VALUE_BITS  = ITDC_VALUE_BITS;
	// Longest correct quiet stretch: one sender gap plus one conversion.
	// Several times that before the watchdog fires.
	localparam int QUIET_LIMIT = 4000;
	// Drain time after the last expected char: longer than one full conversion.
	localparam int END_WAIT    = 200;
	localparam int PHASE_ITEMS = 130;

	// One output char as the unit presents it.
	typedef struct packed {
		logic [6:0] char_code;
		logic       last;
	} text_char_t;

	// Scoreboard: formats each accepted value into the chars the unit should emit,
	// then matches strobed chars in order against the oldest ones waiting.
	class decimal_text_board;
		text_char_t expected_chars[$];
		int         mismatches;

		function void note_value(logic [63:0] raw);
			logic [63:0] mask;
			logic [63:0] v;
			logic [63:0] mag;
			logic        neg;
			logic [3:0]  digits [0:19];
			int          nd;
			int          total;
			int          k;
			mask = (VALUE_BITS == 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
			v    = raw & mask;
			neg  = v[VALUE_BITS-1];
			// Two's complement magnitude; the most negative value lands on 2^(N-1).
			mag  = neg ? ((~v + 64'd1) & mask) : v;
			nd   = 0;
			do begin
				digits[nd] = 4'(mag % 64'd10);
				nd++;
				mag = mag / 64'd10;
			end while (mag != 64'd0);
			total = (neg ? 1 : 0) + nd + (nd - 1) / GROUP_SIZE;
			k     = 0;
			if (neg) begin
				expected_chars.push_back('{char_code: CHAR_MINUS, last: (k == total - 1)});
				k++;
			end
			for (int i = nd - 1; i >= 0; i--) begin
				expected_chars.push_back('{char_code: CHAR_ZERO + {3'b000, digits[i]},
					last: (k == total - 1)});
				k++;
				// separator after each digit whose remaining count is a multiple of three
				if (i > 0 && (i % GROUP_SIZE) == 0) begin
					expected_chars.push_back('{char_code: CHAR_COMMA, last: (k == total - 1)});
					k++;
				end
			end
		endfunction

		function void check_char(logic [6:0] code, logic last_bit);
			text_char_t want;
			if (expected_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected char code %h last %b", $time, code, last_bit);
				return;
			end
			want = expected_chars.pop_front();
			if (code !== want.char_code || last_bit !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: char mismatch: expected code %h last %b, got code %h last %b",
						$time, want.char_code, want.last, code, last_bit);
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	logic [63:0] value  = 64'd0;
	logic        busy;
	logic        strobe;
	logic [6:0]  char_code;
	logic        last;

	decimal_text_board board = new();
	int                quiet_cycles = 0;

	int_to_decimal_with_commas_unit #(
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.strobe(strobe),
		.char_code(char_code),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Monitor + watchdog. Everything is sampled at the rising edge, before the
	// driver's nonblocking updates land, so the view is race free.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_value(value);
			if (strobe)
				board.check_char(char_code, last);
			// watchdog only counts cycles with no transaction on either side
			if ((start && !busy) || strobe)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
				$display("int_to_decimal_with_commas_unit_tb failed");
				$finish;
			end
		end
	end

	// Present one value and hold it until the unit takes it. Returns just after
	// the accepting edge, so a following call keeps start high back to back.
	task automatic send_value(logic [63:0] v);
		start <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Sender idle: start low, junk on value, which the unit must ignore.
	task automatic pause_sender(int cycles);
		start <= 1'b0;
		value <= {$urandom, $urandom};
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending until every queued char has come out. The first edge lets the
	// monitor note the last accepted transaction before the count is read.
	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() != 0);
	endtask

	function automatic logic [63:0] pow10(int k);
		logic [63:0] p;
		p = 64'd1;
		repeat (k) p = p * 64'd10;
		return p;
	endfunction

	// Mix of shapes: full random words for bit coverage, bounded magnitudes so
	// every digit count (and so every comma count) shows up, plus values around
	// the width extremes and powers of ten where digit counts roll over.
	function automatic logic [63:0] random_value();
		logic [63:0] r;
		logic [63:0] mag;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2: return r;
			3, 4, 5, 6: begin
				mag = r % pow10($urandom_range(1, 19));
				return $urandom_range(0, 1) ? -mag : mag;
			end
			7: begin
				mag = 64'($urandom_range(0, 300));
				return $urandom_range(0, 1) ? (64'h8000_0000_0000_0000 + mag)
					: (64'h7fff_ffff_ffff_ffff - mag);
			end
			default: begin
				mag = pow10($urandom_range(0, 18)) + 64'($urandom_range(0, 2)) - 64'd1;
				return $urandom_range(0, 1) ? -mag : mag;
			end
		endcase
	endfunction

	initial begin
		logic [63:0] directed [$];
		int          idle_pct [3];
		directed = '{
			64'd0, 64'd1, -64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd999,
			64'd1000, -64'd1000, 64'd999_999, 64'd1_000_000, 64'd12_345_678,
			-64'd12_345_678, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
			64'h8000_0000_0000_0001, 64'd1_000_000_000_000_000_000,
			64'd999_999_999_999_999_999, -64'd1_000_000_000_000_000_000,
			64'h0000_0001_0000_0000, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa
		};
		// no idling, heavy sender idling, light sender idling
		idle_pct = '{0, 70, 8};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed values back to back, then a full drain.
		foreach (directed[i])
			send_value(directed[i]);
		drain_results();

		for (int p = 0; p < 3; p++) begin
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// gaps of varying length land on every step of a conversion
				if ($urandom_range(0, 99) < idle_pct[p])
					pause_sender($urandom_range(1, 120));
				send_value(random_value());
			end
			drain_results();
		end

		repeat (END_WAIT) @(posedge clk);
		if (board.pending() != 0)
			$display("%0d expected chars never arrived", board.pending());

		if (board.mismatches == 0 && board.pending() == 0)
			$display("int_to_decimal_with_commas_unit_tb passed");
		else
			$display("int_to_decimal_with_commas_unit_tb failed");
		$finish;
	end

endmodule

>>> int_to_decimal_with_commas_unit.f
rtl/itdc_pkg.sv
rtl/itdc_dabble.sv
rtl/int_to_decimal_with_commas_unit.sv
test/int_to_decimal_with_commas_unit_tb.sv
